>>> rtl/core/lir_pkg.sv
// ----------------------------------------------------------------------------
// lir_pkg
// Shared codes for the line interior rasterizer: item modes and the bit
// positions of the step direction flags.
// ----------------------------------------------------------------------------
package lir_pkg;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_STEP = 1'b1
    } t_mode;

    // step direction flags
    localparam int SGN_X_UP = 0;
    localparam int SGN_X_DN = 1;
    localparam int SGN_Y_UP = 2;
    localparam int SGN_Y_DN = 3;
    localparam int SGN_BITS = 4;

endpackage

>>> rtl/core/line_interior_rasterizer.sv
// ----------------------------------------------------------------------------
// line_interior_rasterizer
// Bresenham line stepper: a load item sets up a line, each step item yields
// the next interior pixel while any are left (endpoints excluded).
// ----------------------------------------------------------------------------
// Pipeline: input register, then setup or step logic into the result
// register.
// Throughput: one item per cycle while the output is not stalled; the error
// update and coordinate step close on the line state registers.
// Reset: synchronous; clears the line state (no line active) and both valids.
// ----------------------------------------------------------------------------
module line_interior_rasterizer #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_mode,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [COORD_BITS-1:0] o_pixel_x,
    output logic signed [COORD_BITS-1:0] o_pixel_y,
    output logic                         o_last_pixel
);
    import lir_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int EW = COORD_BITS + 3;

    // input register
    logic                         r_in_valid;
    t_mode                        r_mode;
    logic signed [COORD_BITS-1:0] r_start_x;
    logic signed [COORD_BITS-1:0] r_start_y;
    logic signed [COORD_BITS-1:0] r_end_x;
    logic signed [COORD_BITS-1:0] r_end_y;

    // line state
    logic [COORD_BITS-1:0] r_cur_x;
    logic [COORD_BITS-1:0] r_cur_y;
    logic signed [EW-1:0]  r_error;
    logic [DW-1:0]         r_major;
    logic [DW-1:0]         r_minor;
    logic [SGN_BITS-1:0]   r_signs;
    logic                  r_y_major;
    logic [DW-1:0]         r_pixels_left;

    // result register
    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_pix_x;
    logic [COORD_BITS-1:0] r_pix_y;
    logic                  r_last;

    // setup results
    logic [DW-1:0]        su_major;
    logic [DW-1:0]        su_minor;
    logic signed [EW-1:0] su_error;
    logic [SGN_BITS-1:0]  su_signs;
    logic                 su_y_major;
    logic [DW-1:0]        su_pixels_left;

    // step logic
    logic                  out_free;
    logic                  advance;
    logic                  do_step;
    logic                  err_pos;
    logic                  maj_up, maj_dn, min_up, min_dn;
    logic [COORD_BITS-1:0] maj_cur, min_cur;
    logic [COORD_BITS-1:0] n_maj, n_min;
    logic [COORD_BITS-1:0] n_cur_x, n_cur_y;
    logic signed [EW-1:0]  n_error;

    lir_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .i_start_x     (r_start_x),
        .i_start_y     (r_start_y),
        .i_end_x       (r_end_x),
        .i_end_y       (r_end_y),
        .o_major_delta (su_major),
        .o_minor_delta (su_minor),
        .o_error_init  (su_error),
        .o_step_signs  (su_signs),
        .o_y_major     (su_y_major),
        .o_pixels_left (su_pixels_left)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign do_step  = advance && (r_mode == MODE_STEP) && (r_pixels_left != '0);

    assign maj_up  = r_y_major ? r_signs[SGN_Y_UP] : r_signs[SGN_X_UP];
    assign maj_dn  = r_y_major ? r_signs[SGN_Y_DN] : r_signs[SGN_X_DN];
    assign min_up  = r_y_major ? r_signs[SGN_X_UP] : r_signs[SGN_Y_UP];
    assign min_dn  = r_y_major ? r_signs[SGN_X_DN] : r_signs[SGN_Y_DN];
    assign maj_cur = r_y_major ? r_cur_y : r_cur_x;
    assign min_cur = r_y_major ? r_cur_x : r_cur_y;

    assign err_pos = !r_error[EW-1] && (r_error != '0);

    always_comb begin
        n_maj = maj_cur;
        if (maj_up) begin
            n_maj = maj_cur + COORD_BITS'(1);
        end else if (maj_dn) begin
            n_maj = maj_cur - COORD_BITS'(1);
        end
        n_min = min_cur;
        if (err_pos && min_up) begin
            n_min = min_cur + COORD_BITS'(1);
        end else if (err_pos && min_dn) begin
            n_min = min_cur - COORD_BITS'(1);
        end
    end

    assign n_cur_x = r_y_major ? n_min : n_maj;
    assign n_cur_y = r_y_major ? n_maj : n_min;

    // modular add; the true value always fits EW bits
    assign n_error = r_error
                   - (err_pos ? $signed({1'b0, r_major, 1'b0}) : EW'(0))
                   + $signed({1'b0, r_minor, 1'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_cur_x       <= '0;
            r_cur_y       <= '0;
            r_error       <= '0;
            r_major       <= '0;
            r_minor       <= '0;
            r_signs       <= '0;
            r_y_major     <= 1'b0;
            r_pixels_left <= '0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= do_step;
            end
            if (advance && (r_mode == MODE_LOAD)) begin
                r_cur_x       <= r_start_x;
                r_cur_y       <= r_start_y;
                r_error       <= su_error;
                r_major       <= su_major;
                r_minor       <= su_minor;
                r_signs       <= su_signs;
                r_y_major     <= su_y_major;
                r_pixels_left <= su_pixels_left;
            end else if (do_step) begin
                r_cur_x       <= n_cur_x;
                r_cur_y       <= n_cur_y;
                r_error       <= n_error;
                r_pixels_left <= r_pixels_left - DW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_mode    <= t_mode'(i_mode);
            r_start_x <= i_start_x;
            r_start_y <= i_start_y;
            r_end_x   <= i_end_x;
            r_end_y   <= i_end_y;
        end
        if (do_step) begin
            r_pix_x <= n_cur_x;
            r_pix_y <= n_cur_y;
            r_last  <= (r_pixels_left == DW'(1));
        end
    end

    assign o_valid      = r_out_valid;
    assign o_pixel_x    = $signed(r_pix_x);
    assign o_pixel_y    = $signed(r_pix_y);
    assign o_last_pixel = r_last;

endmodule

>>> rtl/core/lir_setup.sv
// ----------------------------------------------------------------------------
// lir_setup
// Line setup: deltas, step directions, major axis, initial error term and
// interior pixel count from two endpoints.
// ----------------------------------------------------------------------------
module lir_setup #(
    parameter int COORD_BITS = 16
) (
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output logic [COORD_BITS:0]          o_major_delta,
    output logic [COORD_BITS:0]          o_minor_delta,
    output logic signed [COORD_BITS+2:0] o_error_init,
    output logic [lir_pkg::SGN_BITS-1:0] o_step_signs,
    output logic                         o_y_major,
    output logic [COORD_BITS:0]          o_pixels_left
);
    import lir_pkg::*;

    localparam int DW = COORD_BITS + 1;

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [DW-1:0]        ax;
    logic [DW-1:0]        ay;

    assign dx = $signed({i_end_x[COORD_BITS-1], i_end_x})
              - $signed({i_start_x[COORD_BITS-1], i_start_x});
    assign dy = $signed({i_end_y[COORD_BITS-1], i_end_y})
              - $signed({i_start_y[COORD_BITS-1], i_start_y});

    // magnitude of a negative delta still fits in DW unsigned bits
    assign ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
    assign ay = dy[DW-1] ? DW'(-dy) : DW'(dy);

    always_comb begin
        o_step_signs           = '0;
        o_step_signs[SGN_X_UP] = !dx[DW-1] && (dx != '0);
        o_step_signs[SGN_X_DN] = dx[DW-1];
        o_step_signs[SGN_Y_UP] = !dy[DW-1] && (dy != '0);
        o_step_signs[SGN_Y_DN] = dy[DW-1];
    end

    assign o_y_major     = !(ax > ay);
    assign o_major_delta = o_y_major ? ay : ax;
    assign o_minor_delta = o_y_major ? ax : ay;

    assign o_error_init  = $signed({1'b0, o_minor_delta, 1'b0})
                         - $signed({2'b00, o_major_delta});

    assign o_pixels_left = (o_major_delta > DW'(1)) ? o_major_delta - DW'(1) : '0;

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for line_interior_rasterizer. A directed table covers
// reset, short lines, ties, extreme coordinates and a line being replaced.
// Random line sequences follow: they are mostly complete walks of short lines,
// plus a few long lines, interrupted lines and stray step transfers. Each
// accepted item runs through a local Bresenham predictor, and every result
// transfer is compared with the oldest expected pixel.
// ----------------------------------------------------------------------------
module tb;
    import lir_pkg::*;

    localparam int CB         = 16;
    localparam int N_ITEMS    = 1800;
    localparam int IDLE_LIMIT = 1000;

    typedef struct packed {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic                 last;
    } t_pixel;

    typedef struct packed {
        t_mode                mode;
        logic signed [CB-1:0] sx;
        logic signed [CB-1:0] sy;
        logic signed [CB-1:0] ex;
        logic signed [CB-1:0] ey;
        logic                 typed;  // expected result given in the row
        logic                 has;
        t_pixel               px;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic                 i_mode = 1'b0;
    logic signed [CB-1:0] i_start_x = '0;
    logic signed [CB-1:0] i_start_y = '0;
    logic signed [CB-1:0] i_end_x = '0;
    logic signed [CB-1:0] i_end_y = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic signed [CB-1:0] o_pixel_x;
    logic signed [CB-1:0] o_pixel_y;
    logic                 o_last_pixel;

    line_interior_rasterizer #(.COORD_BITS(CB)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_mode      (i_mode),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_last_pixel(o_last_pixel)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // line state of the predictor
    logic signed [CB-1:0]  ln_x = '0;
    logic signed [CB-1:0]  ln_y = '0;
    logic signed [CB+2:0]  ln_err = '0;
    logic [CB:0]           ln_maj = '0;
    logic [CB:0]           ln_min = '0;
    logic [SGN_BITS-1:0]   ln_dir = '0;
    logic                  ln_ymaj = 1'b0;
    logic [CB:0]           ln_left = '0;

    t_pixel pixel_q[$];
    t_row   dir_rows[$];

    int errors = 0;
    int n_loads = 0;
    int n_steps = 0;
    int n_pixels = 0;
    int n_checked = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    int calm_left = 0;

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
        errors++;
    endtask

    // next interior pixel of a Bresenham walk, or setup on a load
    function automatic bit rast_predict(input t_mode m,
                                        input logic signed [CB-1:0] sx,
                                        input logic signed [CB-1:0] sy,
                                        input logic signed [CB-1:0] ex,
                                        input logic signed [CB-1:0] ey,
                                        output t_pixel px);
        int dx, dy, ax, ay, xdir, ydir, smaj, smin;
        px = '0;
        if (m == MODE_LOAD) begin
            dx = int'(ex) - int'(sx);
            dy = int'(ey) - int'(sy);
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            ln_x = sx;
            ln_y = sy;
            ln_dir = '0;
            if (dx > 0) ln_dir[SGN_X_UP] = 1'b1;
            else if (dx < 0) ln_dir[SGN_X_DN] = 1'b1;
            if (dy > 0) ln_dir[SGN_Y_UP] = 1'b1;
            else if (dy < 0) ln_dir[SGN_Y_DN] = 1'b1;
            ln_ymaj = (ax > ay) ? 1'b0 : 1'b1;  // tie goes to y
            ln_maj = 17'(ln_ymaj ? ay : ax);
            ln_min = 17'(ln_ymaj ? ax : ay);
            ln_err = 19'(2 * int'(ln_min) - int'(ln_maj));
            ln_left = (ln_maj > 1) ? 17'(ln_maj - 1) : '0;
            return 1'b0;
        end
        if (ln_left == 0) return 1'b0;
        xdir = ln_dir[SGN_X_UP] ? 1 : (ln_dir[SGN_X_DN] ? -1 : 0);
        ydir = ln_dir[SGN_Y_UP] ? 1 : (ln_dir[SGN_Y_DN] ? -1 : 0);
        smaj = ln_ymaj ? ydir : xdir;
        smin = ln_ymaj ? xdir : ydir;
        if (ln_err > 0) begin
            if (ln_ymaj) ln_x = 16'(int'(ln_x) + smin);
            else ln_y = 16'(int'(ln_y) + smin);
            ln_err = 19'(int'(ln_err) - 2 * int'(ln_maj));
        end
        ln_err = 19'(int'(ln_err) + 2 * int'(ln_min));
        if (ln_ymaj) ln_y = 16'(int'(ln_y) + smaj);
        else ln_x = 16'(int'(ln_x) + smaj);
        px.x = ln_x;
        px.y = ln_y;
        px.last = (ln_left == 1);
        ln_left = 17'(ln_left - 1);
        return 1'b1;
    endfunction

    // mostly back-to-back, sometimes a short gap, rarely a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic signed [CB-1:0] rand_coord();
        logic signed [CB-1:0] v;
        v = CB'($urandom);
        return v;
    endfunction

    function automatic logic signed [CB-1:0] rand_base();
        if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1)) return 16'(32767 - int'($urandom_range(0, 5)));
            return 16'(-32768 + int'($urandom_range(0, 5)));
        end
        return rand_coord();
    endfunction

    // endpoint within span of base, mirrored back if it would leave the range
    function automatic logic signed [CB-1:0] near_coord(input logic signed [CB-1:0] base,
                                                        input int span);
        int e;
        e = int'(base) + int'($urandom_range(0, 2 * span)) - span;
        if (e > 32767 || e < -32768) e = 2 * int'(base) - e;
        return 16'(e);
    endfunction

    task automatic send_item(input t_mode m,
                             input logic signed [CB-1:0] sx,
                             input logic signed [CB-1:0] sy,
                             input logic signed [CB-1:0] ex,
                             input logic signed [CB-1:0] ey,
                             input bit use_row, input bit row_has, input t_pixel row_px,
                             input bit burst);
        int g;
        bit has;
        t_pixel px;
        g = burst ? 0 : pick_gap();
        repeat (g) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_mode    <= m;
        i_start_x <= sx;
        i_start_y <= sy;
        i_end_x   <= ex;
        i_end_y   <= ey;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        has = rast_predict(m, sx, sy, ex, ey, px);
        if (use_row) begin
            has = row_has;
            px  = row_px;
        end
        if (has) begin
            pixel_q.push_back(px);
            n_pixels++;
        end
        if (m == MODE_LOAD) n_loads++;
        else n_steps++;
    endtask

    task automatic step_item(input bit burst);
        send_item(MODE_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  1'b0, 1'b0, '0, burst);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic add_row(input t_mode m, input int sx, input int sy, input int ex,
                           input int ey, input bit typed, input bit has,
                           input int px, input int py, input bit last);
        t_row r;
        r.mode = m;
        r.sx = 16'(sx);
        r.sy = 16'(sy);
        r.ex = 16'(ex);
        r.ey = 16'(ey);
        r.typed = typed;
        r.has = has;
        r.px.x = 16'(px);
        r.px.y = 16'(py);
        r.px.last = last;
        dir_rows.push_back(r);
    endtask

    // result side
    always @(posedge i_clk) begin
        t_pixel e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pixel_q.size() == 0) begin
                flag_mismatch("pixel with nothing pending, x", int'(o_pixel_x), 0);
            end else begin
                e = pixel_q.pop_front();
                n_checked++;
                if (o_pixel_x !== e.x) flag_mismatch("pixel_x", int'(o_pixel_x), int'(e.x));
                if (o_pixel_y !== e.y) flag_mismatch("pixel_y", int'(o_pixel_y), int'(e.y));
                if (o_last_pixel !== e.last)
                    flag_mismatch("last_pixel", int'(o_last_pixel), int'(e.last));
            end
        end
    end

    // receiver stalls, with calm stretches now and then
    always @(negedge i_clk) begin
        int g;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            if (calm_left > 0) calm_left--;
            else if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(50, 300);
            g = (calm_left > 0) ? 0 : pick_gap();
            if (g > 0) begin
                i_stall <= 1'b1;
                stall_left = g - 1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d idle cycles, %0d pixels pending",
                         idle_cycles, pixel_q.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        int kind, span, nsteps, k, i;
        bit burst, paused;
        logic signed [CB-1:0] sx, sy;
        t_row r;

        // after reset, lines, tie, short lines, extremes, replacement
        add_row(MODE_STEP, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        add_row(MODE_LOAD, 0, 0, 3, 0, 1, 0, 0, 0, 0);
        add_row(MODE_STEP, 0, 0, 0, 0, 1, 1, 1, 0, 0);
        add_row(MODE_STEP, 0, 0, 0, 0, 1, 1, 2, 0, 1);
        add_row(MODE_STEP, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        add_row(MODE_LOAD, 0, 0, 2, 2, 1, 0, 0, 0, 0);
        add_row(MODE_STEP, 0, 0, 0, 0, 1, 1, 1, 1, 1);
        add_row(MODE_LOAD, 5, 5, 6, 6, 1, 0, 0, 0, 0);
        add_row(MODE_STEP, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        add_row(MODE_LOAD, 7, 7, 7, 7, 1, 0, 0, 0, 0);
        add_row(MODE_STEP, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        add_row(MODE_LOAD, -32768, -32768, 32767, 32767, 1, 0, 0, 0, 0);
        add_row(MODE_STEP, 0, 0, 0, 0, 1, 1, -32767, -32767, 0);
        add_row(MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_LOAD, 32767, -32768, -32768, 32767, 1, 0, 0, 0, 0);
        add_row(MODE_STEP, 0, 0, 0, 0, 1, 1, 32766, -32767, 0);
        add_row(MODE_LOAD, -32768, 0, 32767, 0, 1, 0, 0, 0, 0);
        add_row(MODE_STEP, 0, 0, 0, 0, 1, 1, -32767, 0, 0);
        add_row(MODE_LOAD, 0, 0, 0, -3, 1, 0, 0, 0, 0);
        add_row(MODE_STEP, 0, 0, 0, 0, 1, 1, 0, -1, 0);
        add_row(MODE_LOAD, 100, 0, -100, 3, 0, 0, 0, 0, 0);
        add_row(MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_LOAD, 0, 10, -5, -2, 0, 0, 0, 0, 0);
        add_row(MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < dir_rows.size(); i++) begin
            r = dir_rows[i];
            send_item(r.mode, r.sx, r.sy, r.ex, r.ey, r.typed, r.has, r.px, 1'b0);
        end
        wait_drained();

        paused = 1'b0;
        while (n_loads + n_steps < N_ITEMS) begin
            burst = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 99);
            if (!paused && n_loads + n_steps >= N_ITEMS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            if (kind < 88) begin
                sx = rand_base();
                sy = rand_base();
                if (kind < 70) span = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(0, 12);
                else if (kind < 71) span = $urandom_range(200, 600);
                else span = 0;
                if (span > 0)
                    send_item(MODE_LOAD, sx, sy, near_coord(sx, span), near_coord(sy, span),
                              1'b0, 1'b0, '0, burst);
                else
                    send_item(MODE_LOAD, sx, sy, rand_coord(), rand_coord(),
                              1'b0, 1'b0, '0, burst);
                // full walk with a few extra steps, or cut short by the next load
                if (span == 0 || $urandom_range(0, 6) == 0)
                    nsteps = $urandom_range(0, (ln_left > 20) ? 20 : int'(ln_left));
                else
                    nsteps = int'(ln_left) + $urandom_range(0, 2);
                for (k = 0; k < nsteps; k++) step_item(burst);
            end else if (kind < 95) begin
                nsteps = $urandom_range(1, 4);
                for (k = 0; k < nsteps; k++) step_item(burst);
            end else begin
                // back-to-back loads: only the second one counts
                send_item(MODE_LOAD, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                          1'b0, 1'b0, '0, burst);
                sx = rand_base();
                sy = rand_base();
                send_item(MODE_LOAD, sx, sy, near_coord(sx, 9), near_coord(sy, 9),
                          1'b0, 1'b0, '0, burst);
                nsteps = int'(ln_left) + 1;
                for (k = 0; k < nsteps; k++) step_item(burst);
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d loads and %0d step transfers; %0d pixels checked, %0d mismatches",
                 n_loads, n_steps, n_checked, errors);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/lir_pkg.sv
rtl/core/lir_setup.sv
rtl/core/line_interior_rasterizer.sv
sim/tb.sv
